FILE: hw/rtl/mss_pkg.sv
// Package for the marquee scroll sequencer: command codes, register
// indexes, reset values and fixed port widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

  // Default pixel coordinate width
  localparam int unsigned WIDTH_BITS_DEF = 10;

  // Fixed widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned MODE_W     = 3;

  // Mode flag bits
  localparam int unsigned MODE_FIT_ONLY    = 0;
  localparam int unsigned MODE_START_VIS   = 1;
  localparam int unsigned MODE_RIGHT_ALIGN = 2;

  // Reset values
  localparam int unsigned RST_DISPLAY_WIDTH = 128;
  localparam int unsigned RST_FRAME_DIV     = 2;
  localparam int unsigned RST_STEP_SIZE     = 1;
  localparam int unsigned RST_MODE_FLAGS    = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_REWIND  = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NOP     = 2'd3
  } mss_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_WIDTH = 3'd0,
    REG_TEXT_WIDTH    = 3'd1,
    REG_LEFT_MARGIN   = 3'd2,
    REG_HOLDOFF       = 3'd3,
    REG_REAPPEAR      = 3'd4,
    REG_FRAME_DIV     = 3'd5,
    REG_STEP_SIZE     = 3'd6,
    REG_MODE_FLAGS    = 3'd7
  } mss_reg_e;

endpackage

`default_nettype wire

FILE: hw/rtl/marquee_scroll_sequencer.sv
// Marquee scroll sequencer top level: command input register, scroll state
// update and result register in one module.
// Depends on mss_pkg.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: func[1:0], freeze[2]
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: x_offset, is_static, waiting
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One command per cycle while m_axis is not stalled; a command passes through the
// input register and then the result register before m_axis_tvalid rises.
// The scroll state is updated as a command moves into the result register,
// so the next command sees the updated state.
// A stalled m_axis holds the result; one more command waits in the input
// register before s_axis_tready drops. cfg_ready_o is always high.
// Reset clears the scroll state and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module marquee_scroll_sequencer #(
  parameter int unsigned WIDTH_BITS = mss_pkg::WIDTH_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [mss_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // func[1:0], freeze[2]
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // x_offset[WIDTH_BITS:0], is_static[WIDTH_BITS+1], waiting[WIDTH_BITS+2]
  output logic [((WIDTH_BITS+3+7)/8)*8-1:0]    m_axis_tdata,
  // register writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import mss_pkg::*;

  localparam int unsigned WB   = WIDTH_BITS;
  localparam int unsigned XW   = WIDTH_BITS + 1;
  localparam int unsigned SW   = WIDTH_BITS + 3;  // position plus one step of headroom

  localparam logic [WB-1:0]     DispRst = WB'(RST_DISPLAY_WIDTH);
  localparam logic [DIV_W-1:0]  DivRst  = DIV_W'(RST_FRAME_DIV);
  localparam logic [STEP_W-1:0] StepRst = STEP_W'(RST_STEP_SIZE);
  localparam logic [MODE_W-1:0] ModeRst = MODE_W'(RST_MODE_FLAGS);

  // ---------------------------------------------------------------- config
  logic [WB-1:0]     disp_w_q, text_w_q, margin_q;
  logic [WAIT_W-1:0] holdoff_q, reappear_q;
  logic [DIV_W-1:0]  div_q;
  logic [STEP_W-1:0] step_q;
  logic [MODE_W-1:0] mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q   <= DispRst;
      text_w_q   <= '0;
      margin_q   <= '0;
      holdoff_q  <= '0;
      reappear_q <= '0;
      div_q      <= DivRst;
      step_q     <= StepRst;
      mode_q     <= ModeRst;
    end else if (cfg_valid_i) begin
      unique case (mss_reg_e'(cfg_index_i))
        REG_DISPLAY_WIDTH: disp_w_q   <= cfg_data_i[WB-1:0];
        REG_TEXT_WIDTH:    text_w_q   <= cfg_data_i[WB-1:0];
        REG_LEFT_MARGIN:   margin_q   <= cfg_data_i[WB-1:0];
        REG_HOLDOFF:       holdoff_q  <= cfg_data_i[WAIT_W-1:0];
        REG_REAPPEAR:      reappear_q <= cfg_data_i[WAIT_W-1:0];
        REG_FRAME_DIV:     div_q      <= cfg_data_i[DIV_W-1:0];
        REG_STEP_SIZE:     step_q     <= cfg_data_i[STEP_W-1:0];
        REG_MODE_FLAGS:    mode_q     <= cfg_data_i[MODE_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------- handshakes
  logic      s1_valid_q;
  mss_func_e s1_func_q;
  logic      s1_freeze_q;
  logic      out_valid_q;
  logic      adv;   // result register can take the input register's item
  logic      load;  // an item moves into the result register

  assign adv           = !out_valid_q || m_axis_tready;
  assign load          = adv && s1_valid_q;
  assign s_axis_tready = !s1_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_func_q   <= mss_func_e'(s_axis_tdata[FUNC_W-1:0]);
      s1_freeze_q <= s_axis_tdata[FUNC_W];
    end
  end

  // ---------------------------------------------------------- scroll state
  logic signed [SW-1:0] pos_q, pos_d;
  logic                 started_q, started_d;
  logic [DIV_W-1:0]     phase_q, phase_d;
  logic [WAIT_W-1:0]    wait_q, wait_d;

  logic signed [SW-1:0] w_s, t_s, m_s, step_s, margin_pt, base_pos, sum_pos;
  logic [WAIT_W-1:0]    base_wait;
  logic [DIV_W-1:0]     div_eff;
  logic                 still, step_now;
  logic signed [SW-1:0] x_full;
  logic                 is_static_d;

  always_comb begin
    w_s       = $signed({{(SW-WB){1'b0}}, disp_w_q});
    t_s       = $signed({{(SW-WB){1'b0}}, text_w_q});
    m_s       = $signed({{(SW-WB){1'b0}}, margin_q});
    step_s    = $signed({{(SW-STEP_W){1'b0}}, step_q});
    margin_pt = w_s - m_s;
    div_eff   = (div_q == '0) ? DIV_W'(1) : div_q;
    still     = s1_freeze_q || (mode_q[MODE_FIT_ONLY] && (text_w_q <= disp_w_q));

    // first scrolling tick places the position
    if (!started_q) begin
      base_pos  = mode_q[MODE_START_VIS] ? margin_pt : '1;
      base_wait = mode_q[MODE_START_VIS] ? holdoff_q : wait_q;
    end else begin
      base_pos  = pos_q;
      base_wait = wait_q;
    end
    sum_pos  = base_pos + step_s;
    step_now = ({1'b0, phase_q} + 9'd1) >= {1'b0, div_eff};

    pos_d       = pos_q;
    started_d   = started_q;
    phase_d     = phase_q;
    wait_d      = wait_q;
    is_static_d = 1'b0;
    x_full      = '0;

    unique case (s1_func_q)
      FUNC_REWIND: begin
        pos_d     = '0;
        started_d = 1'b1;
        x_full    = w_s - SW'(1);
      end
      FUNC_RESTART: begin
        started_d = 1'b0;
        phase_d   = '0;
      end
      FUNC_NOP: begin
        x_full = started_q ? (w_s - pos_q - SW'(1)) : '0;
      end
      FUNC_TICK: begin
        if (still) begin
          is_static_d = 1'b1;
          x_full      = mode_q[MODE_RIGHT_ALIGN] ? (w_s - t_s) : '0;
        end else begin
          started_d = 1'b1;
          pos_d     = base_pos;
          wait_d    = base_wait;
          if (step_now) begin
            phase_d = '0;
            if (base_wait == '0) begin
              if (sum_pos >= (w_s + t_s)) begin
                pos_d  = '1;  // wrap to just off the right edge
                wait_d = reappear_q;
              end else begin
                pos_d = sum_pos;
                if (sum_pos == margin_pt) begin
                  wait_d = holdoff_q;
                end
              end
            end else begin
              wait_d = base_wait - WAIT_W'(1);
            end
          end else begin
            phase_d = phase_q + DIV_W'(1);
          end
          x_full = w_s - pos_d - SW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      started_q <= 1'b0;
      phase_q   <= '0;
      wait_q    <= '0;
    end else if (load) begin
      pos_q     <= pos_d;
      started_q <= started_d;
      phase_q   <= phase_d;
      wait_q    <= wait_d;
    end
  end

  // ---------------------------------------------------------- result register
  logic [XW-1:0] out_x_q;
  logic          out_static_q;
  logic          out_waiting_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_x_q       <= x_full[XW-1:0];
      out_static_q  <= is_static_d;
      out_waiting_q <= (wait_d != '0);
    end
  end

  always_comb begin
    m_axis_tdata           = '0;
    m_axis_tdata[XW-1:0]   = out_x_q;
    m_axis_tdata[XW]       = out_static_q;
    m_axis_tdata[XW+1]     = out_waiting_q;
  end

  // ---------------------------------------------------------- assertions
  a_tready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register stage");

  a_rewind_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && s1_func_q == FUNC_REWIND) |=> (started_q && pos_q == '0))
    else $error("rewind did not start the position at zero");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && s1_func_q == FUNC_RESTART) |=> (!started_q && phase_q == '0))
    else $error("restart did not clear the scroll state");

  a_waiting_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_waiting_q == (wait_q != '0)))
    else $error("waiting flag disagrees with the wait counter");

endmodule

`default_nettype wire
